@@ design/lprd_pkg.sv @@
// Package for the length-prefixed row deframer.
// Holds the word types of both channels, the configuration type and register indexes.
// Used by lprd_parser and length_prefixed_row_deframer; depends on nothing.
package lprd_pkg;

    localparam int ROW_COUNT_WIDTH_DEFAULT = 32;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 8;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PREFIX_SIZE_LOG2  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PREFIX_BIG_ENDIAN = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ITEM_SIZE         = 2'd2;

    localparam logic [1:0] PREFIX_SIZE_LOG2_RESET  = 2'd2;
    localparam logic       PREFIX_BIG_ENDIAN_RESET = 1'b0;
    localparam logic [7:0] ITEM_SIZE_RESET         = 8'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        is_payload;
        logic [31:0] row_index;
        logic        row_end;
        logic        done_res;
        logic [31:0] row_count;
        logic        corrupt;
    } out_word_t;

    typedef struct packed {
        logic [1:0] prefix_size_log2;
        logic       prefix_big_endian;
        logic [7:0] item_size;
    } cfg_t;

endpackage

@@ design/lprd_parser.sv @@
// Per-byte parsing state and next-state logic of the row deframer.
// Tracks prefix bytes, row length, remaining payload bytes and the row counter.
// Depends on lprd_pkg.
module lprd_parser #(
    parameter int ROW_COUNT_WIDTH = lprd_pkg::ROW_COUNT_WIDTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  lprd_pkg::cfg_t      cfg,
    input  lprd_pkg::in_word_t  word,
    output lprd_pkg::out_word_t result
);

    logic                       in_payload_reg;
    logic                       in_payload_next;
    logic [2:0]                 seen_reg;
    logic [2:0]                 seen_next;
    logic [63:0]                acc_reg;
    logic [63:0]                acc_next;
    logic [63:0]                remaining_reg;
    logic [63:0]                remaining_next;
    logic [ROW_COUNT_WIDTH-1:0] rows_reg;
    logic [ROW_COUNT_WIDTH-1:0] rows_next;

    logic [3:0]                 seen_inc;
    logic [3:0]                 need;
    logic [63:0]                acc_upd;
    logic [71:0]                product;
    logic [63:0]                total;
    logic                       total_zero;
    logic [63:0]                remaining_dec;
    logic                       row_done;
    logic [ROW_COUNT_WIDTH-1:0] rows_inc;
    logic [63:0]                rows_before_ext;
    logic [63:0]                rows_after_ext;

    always_comb
    begin
        seen_inc = {1'b0, seen_reg} + 4'd1;
        need     = 4'd1 << cfg.prefix_size_log2;
        if (cfg.prefix_big_endian)
        begin
            acc_upd = {acc_reg[55:0], word.data_byte};
        end
        else
        begin
            acc_upd = acc_reg | (64'(word.data_byte) << {seen_reg, 3'b000});
        end
        product    = {8'd0, acc_upd} * {64'd0, cfg.item_size};
        total      = (product[71:64] != 8'd0) ? {64{1'b1}} : product[63:0];
        total_zero = (acc_upd == 64'd0) || (cfg.item_size == 8'd0);
        remaining_dec = (remaining_reg != 64'd0) ? remaining_reg - 64'd1 : 64'd0;
        rows_inc = (rows_reg != {ROW_COUNT_WIDTH{1'b1}})
                   ? rows_reg + ROW_COUNT_WIDTH'(1) : rows_reg;

        in_payload_next = in_payload_reg;
        seen_next       = seen_reg;
        acc_next        = acc_reg;
        remaining_next  = remaining_reg;
        row_done        = 1'b0;

        if (!in_payload_reg)
        begin
            if (seen_inc >= need)
            begin
                seen_next = 3'd0;
                acc_next  = 64'd0;
                if (total_zero)
                begin
                    row_done = 1'b1;
                end
                else
                begin
                    in_payload_next = 1'b1;
                    remaining_next  = total;
                end
            end
            else
            begin
                seen_next = seen_inc[2:0];
                acc_next  = acc_upd;
            end
        end
        else
        begin
            remaining_next = remaining_dec;
            if (remaining_dec == 64'd0)
            begin
                row_done        = 1'b1;
                in_payload_next = 1'b0;
            end
        end

        rows_next = row_done ? rows_inc : rows_reg;

        rows_before_ext = 64'(rows_reg);
        rows_after_ext  = 64'(rows_next);

        result.payload_byte = word.data_byte;
        result.is_payload   = in_payload_reg;
        result.row_index    = rows_before_ext[31:0];
        result.row_end      = row_done;
        result.done_res     = word.last_byte;
        result.row_count    = word.last_byte ? rows_after_ext[31:0] : 32'd0;
        result.corrupt      = word.last_byte && (in_payload_next || (seen_next != 3'd0));

        if (word.last_byte)
        begin
            in_payload_next = 1'b0;
            seen_next       = 3'd0;
            acc_next        = 64'd0;
            remaining_next  = 64'd0;
            rows_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_payload_reg <= 1'b0;
            seen_reg       <= 3'd0;
            acc_reg        <= 64'd0;
            remaining_reg  <= 64'd0;
            rows_reg       <= '0;
        end
        else if (step)
        begin
            in_payload_reg <= in_payload_next;
            seen_reg       <= seen_next;
            acc_reg        <= acc_next;
            remaining_reg  <= remaining_next;
            rows_reg       <= rows_next;
        end
    end

endmodule

@@ design/length_prefixed_row_deframer.sv @@
// Top level of the length-prefixed row deframer: handshake stages and configuration.
// Bytes pass input register, parser, result register; throughput is one byte per cycle while
// result_ready is high, set by the single pass through the parser between the two registers.
// Reset clears all parsing state and the row counter and restores the configuration
// to a 4-byte little-endian prefix with an item size of 1.
// Depends on lprd_pkg and lprd_parser.
module length_prefixed_row_deframer #(
    parameter int ROW_COUNT_WIDTH = lprd_pkg::ROW_COUNT_WIDTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wen,
    input  logic [lprd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [lprd_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    input  logic                                  data_valid,
    output logic                                  data_ready,
    input  lprd_pkg::in_word_t                    data_word,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output lprd_pkg::out_word_t                   result_word
);

    lprd_pkg::cfg_t      cfg_reg;
    lprd_pkg::in_word_t  in_word_reg;
    logic                in_valid_reg;
    lprd_pkg::out_word_t out_word_reg;
    logic                out_valid_reg;
    lprd_pkg::out_word_t parsed;
    logic                advance;

    assign advance    = in_valid_reg && (!out_valid_reg || result_ready);
    assign data_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prefix_size_log2  <= lprd_pkg::PREFIX_SIZE_LOG2_RESET;
            cfg_reg.prefix_big_endian <= lprd_pkg::PREFIX_BIG_ENDIAN_RESET;
            cfg_reg.item_size         <= lprd_pkg::ITEM_SIZE_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                lprd_pkg::CFG_PREFIX_SIZE_LOG2:  cfg_reg.prefix_size_log2  <= cfg_data[1:0];
                lprd_pkg::CFG_PREFIX_BIG_ENDIAN: cfg_reg.prefix_big_endian <= cfg_data[0];
                lprd_pkg::CFG_ITEM_SIZE:         cfg_reg.item_size         <= cfg_data[7:0];
                default:                         cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (data_ready)
            begin
                in_valid_reg <= data_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_valid && data_ready)
        begin
            in_word_reg <= data_word;
        end
        if (advance)
        begin
            out_word_reg <= parsed;
        end
    end

    lprd_parser #(
        .ROW_COUNT_WIDTH (ROW_COUNT_WIDTH)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .cfg    (cfg_reg),
        .word   (in_word_reg),
        .result (parsed)
    );

    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

    // A corrupt flag or a row count is only meaningful on the final byte of a buffer.
    a_corrupt_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_word.corrupt |-> result_word.done_res)
        else $error("corrupt reported on a word that does not end the buffer");

    a_count_zero_unless_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_word.done_res |-> result_word.row_count == 32'd0)
        else $error("row count nonzero on a word that does not end the buffer");

    // An empty input stage must always be able to take a word.
    a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> data_ready)
        else $error("input stage empty but not ready");

    // A parsed word moves into the result register in the cycle it leaves the input stage.
    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid)
        else $error("result register empty after an advance");

endmodule
